// File: hw/rtl/swsh_pkg.sv
`default_nettype none

package swsh_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned CNT_W = 7;
  localparam int unsigned POS_W = 6;

  localparam logic [CNT_W-1:0] WLEN_RESET = 7'd64;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Control part of one command handed from front to back
  typedef struct packed {
    logic             is_append;
    logic             rd_valid;
    logic [CNT_W-1:0] count;
  } swsh_flags_t;

  localparam int unsigned FLAGS_W = $bits(swsh_flags_t);

endpackage

`default_nettype wire

// File: hw/rtl/swsh_in_if.sv
`default_nettype none

interface swsh_in_if #(
  parameter int unsigned SAMPLE_BITS = swsh_pkg::SAMPLE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic signed [SAMPLE_BITS-1:0]    sample;
  logic [swsh_pkg::POS_W-1:0]       position;

  modport source (output valid, op, sample, position, input ready);
  modport sink   (input valid, op, sample, position, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/swsh_out_if.sv
`default_nettype none

interface swsh_out_if #(
  parameter int unsigned SAMPLE_BITS = swsh_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] read_value;
  logic                          position_valid;
  logic [swsh_pkg::CNT_W-1:0]    count;
  logic                          window_empty;
  logic signed [SAMPLE_BITS-1:0] maximum;
  logic signed [SAMPLE_BITS-1:0] minimum;

  modport source (output valid, read_value, position_valid, count, window_empty,
                  maximum, minimum, input ready);
  modport sink   (input valid, read_value, position_valid, count, window_empty,
                  maximum, minimum, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/swsh_front.sv
`default_nettype none

module swsh_front #(
  parameter int unsigned DEPTH       = swsh_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = swsh_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  swsh_in_if.sink                             in_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [swsh_pkg::CNT_W-1:0]     cfg_data_i,
  input  wire logic                           cmd_full_i,
  output logic                                cmd_push_o,
  output swsh_pkg::swsh_flags_t               cmd_flags_o,
  output logic [$clog2(DEPTH)-1:0]            cmd_widx_o,
  output logic [$clog2(DEPTH)-1:0]            cmd_ridx_o,
  output logic [$clog2(DEPTH)-1:0]            cmd_oldest_o,
  output logic [SAMPLE_BITS-1:0]              cmd_sample_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CAP   = (DEPTH < 127) ? DEPTH : 127;
  localparam int unsigned SUM_W = ((IDX_W > swsh_pkg::POS_W) ? IDX_W : swsh_pkg::POS_W) + 1;

  logic [swsh_pkg::CNT_W-1:0] wlen_q;
  logic [swsh_pkg::CNT_W-1:0] held_q, held_d;
  logic [IDX_W-1:0]           oldest_q, oldest_d;
  logic [IDX_W-1:0]           next_q, next_d;

  logic                       accept;
  logic                       is_append;
  logic [swsh_pkg::CNT_W-1:0] eff_len;
  logic [IDX_W-1:0]           next_inc;
  logic [IDX_W-1:0]           oldest_inc;
  logic [SUM_W-1:0]           pos_sum;
  logic [SUM_W-1:0]           pos_wrap;
  logic                       pos_ok;

  // Clamp the programmed length into 1..min(DEPTH, 127)
  assign eff_len = (wlen_q == '0) ? swsh_pkg::CNT_W'(1) :
                   ((wlen_q > swsh_pkg::CNT_W'(CAP)) ? swsh_pkg::CNT_W'(CAP) : wlen_q);

  assign in_i.ready = !cmd_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_append  = (in_i.op == swsh_pkg::OP_APPEND);

  assign next_inc   = (next_q == IDX_W'(DEPTH - 1)) ? '0 : next_q + 1'b1;
  assign oldest_inc = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  // Sum stays below twice DEPTH whenever the position is in range
  assign pos_sum  = SUM_W'(oldest_q) + SUM_W'(in_i.position);
  assign pos_wrap = (pos_sum >= SUM_W'(DEPTH)) ? pos_sum - SUM_W'(DEPTH) : pos_sum;
  assign pos_ok   = !is_append && (swsh_pkg::CNT_W'(in_i.position) < held_q);

  always_comb begin
    held_d   = held_q;
    oldest_d = oldest_q;
    next_d   = next_q;
    if (is_append) begin
      next_d = next_inc;
      if (held_q < eff_len) begin
        held_d = held_q + 1'b1;
      end else begin
        oldest_d = oldest_inc;
      end
    end
  end

  assign cmd_push_o            = accept;
  assign cmd_flags_o.is_append = is_append;
  assign cmd_flags_o.rd_valid  = pos_ok;
  assign cmd_flags_o.count     = held_d;
  assign cmd_widx_o            = next_q;
  assign cmd_ridx_o            = pos_wrap[IDX_W-1:0];
  assign cmd_oldest_o          = oldest_d;
  assign cmd_sample_o          = in_i.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= swsh_pkg::WLEN_RESET;
      held_q   <= '0;
      oldest_q <= '0;
      next_q   <= '0;
    end else if (cfg_we_i) begin
      wlen_q   <= cfg_data_i;
      held_q   <= '0;
      oldest_q <= '0;
      next_q   <= '0;
    end else if (accept) begin
      held_q   <= held_d;
      oldest_q <= oldest_d;
      next_q   <= next_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/swsh_queue.sv
`default_nettype none

module swsh_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] slot_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  logic do_push;
  logic do_pop;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/swsh_back.sv
`default_nettype none

module swsh_back #(
  parameter int unsigned DEPTH       = swsh_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = swsh_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_empty_i,
  output logic                             cmd_pop_o,
  input  wire swsh_pkg::swsh_flags_t       cmd_flags_i,
  input  wire logic [$clog2(DEPTH)-1:0]    cmd_widx_i,
  input  wire logic [$clog2(DEPTH)-1:0]    cmd_ridx_i,
  input  wire logic [$clog2(DEPTH)-1:0]    cmd_oldest_i,
  input  wire logic [SAMPLE_BITS-1:0]      cmd_sample_i,
  swsh_out_if.source                       out_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // What the registered read data belongs to
  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_READ  = 2'd1;
  localparam logic [1:0] TAG_FIRST = 2'd2;
  localparam logic [1:0] TAG_NEXT  = 2'd3;

  logic [SAMPLE_BITS-1:0]        mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0]        rdata_q;

  logic [1:0]                    state_q;
  logic [1:0]                    tag_q;
  logic [IDX_W-1:0]              ridx_q;
  logic                          rd_pend_q;
  logic [swsh_pkg::CNT_W-1:0]    scan_left_q;
  logic [IDX_W-1:0]              scan_ptr_q;
  logic                          first_q;
  logic                          out_vld_q;

  logic signed [SAMPLE_BITS-1:0] value_q;
  logic                          pvalid_q;
  logic [swsh_pkg::CNT_W-1:0]    count_q;
  logic signed [SAMPLE_BITS-1:0] max_q;
  logic signed [SAMPLE_BITS-1:0] min_q;

  logic                          slot_free;
  logic                          mem_we;
  logic [IDX_W-1:0]              raddr;
  logic [1:0]                    issue_tag;
  logic [IDX_W-1:0]              scan_inc;

  assign slot_free = !out_vld_q || out_o.ready;
  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i && slot_free;
  assign mem_we    = cmd_pop_o && cmd_flags_i.is_append;
  assign scan_inc  = (scan_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : scan_ptr_q + 1'b1;

  // Issue the positional read first, then one scan read per cycle
  always_comb begin
    issue_tag = TAG_NONE;
    raddr     = scan_ptr_q;
    if (state_q == ST_RUN) begin
      if (rd_pend_q) begin
        raddr     = ridx_q;
        issue_tag = TAG_READ;
      end else if (scan_left_q != '0) begin
        issue_tag = first_q ? TAG_FIRST : TAG_NEXT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_widx_i] <= cmd_sample_i;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tag_q       <= TAG_NONE;
      ridx_q      <= '0;
      rd_pend_q   <= 1'b0;
      scan_left_q <= '0;
      scan_ptr_q  <= '0;
      first_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      tag_q <= issue_tag;
      if (state_q == ST_DRAIN) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            ridx_q      <= cmd_ridx_i;
            rd_pend_q   <= cmd_flags_i.rd_valid;
            scan_left_q <= cmd_flags_i.count;
            scan_ptr_q  <= cmd_oldest_i;
            first_q     <= 1'b1;
            state_q     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
          end else if (scan_left_q != '0) begin
            scan_left_q <= scan_left_q - 1'b1;
            scan_ptr_q  <= scan_inc;
            first_q     <= 1'b0;
          end else begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result word doubles as the accumulator; it only changes while no word is shown
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      value_q  <= '0;
      pvalid_q <= cmd_flags_i.rd_valid;
      count_q  <= cmd_flags_i.count;
      max_q    <= '0;
      min_q    <= '0;
    end else begin
      case (tag_q)
        TAG_READ: begin
          value_q <= rdata_q;
        end
        TAG_FIRST: begin
          max_q <= rdata_q;
          min_q <= rdata_q;
        end
        TAG_NEXT: begin
          if ($signed(rdata_q) > max_q) begin
            max_q <= rdata_q;
          end
          if ($signed(rdata_q) < min_q) begin
            min_q <= rdata_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.read_value     = value_q;
  assign out_o.position_valid = pvalid_q;
  assign out_o.count          = count_q;
  assign out_o.window_empty   = (count_q == '0);
  assign out_o.maximum        = max_q;
  assign out_o.minimum        = min_q;

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_sample_history.sv
`default_nettype none

// Channel     | Dir | Word contents
// ------------+-----+--------------------------------------------------------
// in_i        | in  | op, sample, position (valid/ready)
// out_o       | out | read_value, position_valid, count, window_empty,
//             |     | maximum, minimum (valid/ready)
// cfg_we_i/.. | in  | window_length write, clears the window
//
// Scan: the scan unit reads the count held samples from the oldest, one entry per
// cycle through the single read port of the sample memory, after the positional
// read when the word reads a held position (count is the number of held samples
// after the word, up to 64 by default).
// Reset: pointers and count clear, window length returns to 64; the sample
// memory is not cleared, only entries that were written are ever read.
// Stalls: a two-entry command queue lets the front take new words while the
// scan unit is busy or a finished word waits on out_o.ready.
module sliding_window_sample_history #(
  parameter int unsigned DEPTH       = swsh_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = swsh_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [swsh_pkg::CNT_W-1:0] cfg_data_i,
  swsh_in_if.sink                         in_i,
  swsh_out_if.source                      out_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CAP   = (DEPTH < 127) ? DEPTH : 127;
  localparam int unsigned CMD_W = swsh_pkg::FLAGS_W + 3 * IDX_W + SAMPLE_BITS;

  // Front to queue
  logic                  f_push;
  swsh_pkg::swsh_flags_t f_flags;
  logic [IDX_W-1:0]      f_widx;
  logic [IDX_W-1:0]      f_ridx;
  logic [IDX_W-1:0]      f_oldest;
  logic [SAMPLE_BITS-1:0] f_sample;
  logic                  q_full;

  // Queue to back
  logic [CMD_W-1:0]      q_din;
  logic [CMD_W-1:0]      q_dout;
  logic                  q_empty;
  logic                  b_pop;
  swsh_pkg::swsh_flags_t b_flags;
  logic [IDX_W-1:0]      b_widx;
  logic [IDX_W-1:0]      b_ridx;
  logic [IDX_W-1:0]      b_oldest;
  logic [SAMPLE_BITS-1:0] b_sample;

  // Classify the word and advance the window pointers at accept time
  swsh_front #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_full_i   (q_full),
    .cmd_push_o   (f_push),
    .cmd_flags_o  (f_flags),
    .cmd_widx_o   (f_widx),
    .cmd_ridx_o   (f_ridx),
    .cmd_oldest_o (f_oldest),
    .cmd_sample_o (f_sample)
  );

  assign q_din = {f_flags, f_widx, f_ridx, f_oldest, f_sample};

  swsh_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (q_dout),
    .empty_o (q_empty)
  );

  assign {b_flags, b_widx, b_ridx, b_oldest, b_sample} = q_dout;

  // Write an appended sample or read the held position, then scan the held entries from the oldest
  swsh_back #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (b_pop),
    .cmd_flags_i  (b_flags),
    .cmd_widx_i   (b_widx),
    .cmd_ridx_i   (b_ridx),
    .cmd_oldest_i (b_oldest),
    .cmd_sample_i (b_sample),
    .out_o        (out_o)
  );

  // The front must never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_push |-> !q_full)
    else $error("command pushed into full queue");

  // The back pops only what is there
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // An empty window reports zero extremes and no valid read
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.window_empty) |->
      (out_o.maximum == '0 && out_o.minimum == '0 && !out_o.position_valid))
    else $error("empty window with nonzero result");

  // The held count never exceeds the capacity of the window
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.count <= swsh_pkg::CNT_W'(CAP)))
    else $error("held count beyond window capacity");

endmodule

`default_nettype wire
